// ===== sv/mqpf_pkg.sv =====
// mqpf_pkg: shared types, codes and helper functions of the MQTT packet field parser
// used by mqpf_step and mqtt_packet_field_parser; no dependencies
package mqpf_pkg;

  // length field bytes before an overflow is flagged (1 to 4)
  localparam int MAX_LENGTH_BYTES = 4;

  localparam int REM_W = 28;
  localparam int FLD_W = 16;

  // parse phases, one-hot
  typedef enum logic [13:0] {
    PH_HDR     = 14'b00000000000001,
    PH_LEN     = 14'b00000000000010,
    PH_SKIP    = 14'b00000000000100,
    PH_CSKIP   = 14'b00000000001000,
    PH_CFLAGS  = 14'b00000000010000,
    PH_KA_HI   = 14'b00000000100000,
    PH_KA_LO   = 14'b00000001000000,
    PH_SLEN_HI = 14'b00000010000000,
    PH_SLEN_LO = 14'b00000100000000,
    PH_SBYTES  = 14'b00001000000000,
    PH_PID_HI  = 14'b00010000000000,
    PH_PID_LO  = 14'b00100000000000,
    PH_PAYLOAD = 14'b01000000000000,
    PH_QOS     = 14'b10000000000000
  } phase_t;

  // event kinds
  localparam logic [3:0] K_HEADER   = 4'd0;
  localparam logic [3:0] K_LENGTH   = 4'd1;
  localparam logic [3:0] K_CFLAGS   = 4'd2;
  localparam logic [3:0] K_KEEPALV  = 4'd3;
  localparam logic [3:0] K_PID      = 4'd4;
  localparam logic [3:0] K_SLEN     = 4'd5;
  localparam logic [3:0] K_SBYTE    = 4'd6;
  localparam logic [3:0] K_REQQOS   = 4'd7;
  localparam logic [3:0] K_PAYLOAD  = 4'd8;
  localparam logic [3:0] K_ERROR    = 4'd9;
  localparam logic [3:0] K_SKIPPED  = 4'd10;

  // error codes
  localparam logic [REM_W-1:0] E_OVERFLOW    = 28'd1;
  localparam logic [REM_W-1:0] E_UNDERRUN    = 28'd2;
  localparam logic [REM_W-1:0] E_UNSUPPORTED = 28'd3;

  // string roles
  localparam logic [2:0] R_NONE     = 3'd0;
  localparam logic [2:0] R_CLIENTID = 3'd1;
  localparam logic [2:0] R_WTOPIC   = 3'd2;
  localparam logic [2:0] R_WMSG     = 3'd3;
  localparam logic [2:0] R_USER     = 3'd4;
  localparam logic [2:0] R_PASSWORD = 3'd5;
  localparam logic [2:0] R_TOPIC    = 3'd6;

  // control packet types
  localparam logic [3:0] T_CONNECT     = 4'd1;
  localparam logic [3:0] T_PUBLISH     = 4'd3;
  localparam logic [3:0] T_PUBACK      = 4'd4;
  localparam logic [3:0] T_PUBREC      = 4'd5;
  localparam logic [3:0] T_PUBREL      = 4'd6;
  localparam logic [3:0] T_PUBCOMP     = 4'd7;
  localparam logic [3:0] T_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] T_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] T_UNSUBACK    = 4'd11;
  localparam logic [3:0] T_PINGREQ     = 4'd12;
  localparam logic [3:0] T_PINGRESP    = 4'd13;
  localparam logic [3:0] T_DISCONNECT  = 4'd14;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t           phase;
    logic [3:0]       cur_type;
    logic [3:0]       hdr_flags;
    logic [2:0]       len_count;
    logic [REM_W-1:0] remaining;
    logic [FLD_W-1:0] field_left;
    logic [7:0]       word_high;
    logic [7:0]       cflags;
    logic [2:0]       role;
  } state_t;

  // one result word
  typedef struct packed {
    logic             emit;
    logic [3:0]       kind;
    logic [REM_W-1:0] value;
    logic [2:0]       role;
    logic [3:0]       ptype;
    logic             eop;
  } result_t;

  // packet may end after this phase without an underrun
  function automatic logic phase_complete(input phase_t ph, input logic [3:0] ptype);
    phase_complete = (ph == PH_SKIP) || (ph == PH_PAYLOAD) ||
                     ((ph == PH_SLEN_HI) &&
                      ((ptype == T_SUBSCRIBE) || (ptype == T_UNSUBSCRIBE)));
  endfunction

  // next optional connect string, none when zero
  function automatic logic [2:0] connect_next_role(input logic [2:0] r, input logic [7:0] f);
    priority if ((r < R_WTOPIC) && f[2]) begin
      connect_next_role = R_WTOPIC;
    end else if (r == R_WTOPIC) begin
      connect_next_role = R_WMSG;
    end else if ((r < R_USER) && f[7]) begin
      connect_next_role = R_USER;
    end else if ((r < R_PASSWORD) && f[6]) begin
      connect_next_role = R_PASSWORD;
    end else begin
      connect_next_role = R_NONE;
    end
  endfunction

endpackage

// ===== sv/mqtt_packet_field_parser.sv =====
// mqtt_packet_field_parser: MQTT 3.1.1 byte stream to field events
// depends on mqpf_pkg and mqpf_step
// path: a byte is held in the input register, then parsed into the result register
//   once the result register can load
// throughput: one byte per cycle unless the output stalls; one parser state update per byte
// reset (rst, synchronous): parser awaits a fixed header, input and result registers empty
// bytes that give no event (length continuation, high byte of a word) still take a parser step
module mqtt_packet_field_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  item_kind,
  output logic [27:0] field_value,
  output logic [2:0]  string_role,
  output logic [3:0]  ctrl_type,
  output logic        end_of_packet
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  mqpf_pkg::state_t  state;
  mqpf_pkg::state_t  state_next;
  mqpf_pkg::result_t res;
  logic              out_free;
  logic              proc;

  // handshake: a held word advances when the result register can load
  assign out_free = !out_valid || out_ready;
  assign proc     = s1_valid && out_free;
  assign in_ready = !s1_valid || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  // per-byte parse logic
  mqpf_step u_step (
    .cur     (state),
    .in_byte (s1_byte),
    .nxt     (state_next),
    .res     (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= mqpf_pkg::PH_HDR;
      state.cur_type   <= 4'd0;
      state.hdr_flags  <= 4'd0;
      state.len_count  <= 3'd0;
      state.remaining  <= '0;
      state.field_left <= '0;
      state.word_high  <= 8'd0;
      state.cflags     <= 8'd0;
      state.role       <= mqpf_pkg::R_NONE;
    end else if (proc) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.emit) begin
      item_kind     <= res.kind;
      field_value   <= res.value;
      string_role   <= res.role;
      ctrl_type     <= res.ptype;
      end_of_packet <= res.eop;
    end
  end

  // checks
  a_reset_phase: assert property (@(posedge clk) rst |=> state.phase == mqpf_pkg::PH_HDR)
    else $error("parser not awaiting a header after reset");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state.phase))
    else $error("parse phase is not one-hot");

  a_role_only_on_strings: assert property (@(posedge clk) disable iff (rst)
      out_valid && (string_role != mqpf_pkg::R_NONE) |->
      (item_kind == mqpf_pkg::K_SLEN) || (item_kind == mqpf_pkg::K_SBYTE))
    else $error("string role on a non-string event");

  a_held_word_stays: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !proc |=> s1_valid && $stable(s1_byte) && $stable(state))
    else $error("held input word or parser state changed while stalled");

endmodule

// ===== sv/mqpf_step.sv =====
// mqpf_step: per-byte parse logic, next state and result word from state and byte
// depends on mqpf_pkg
module mqpf_step (
  input  mqpf_pkg::state_t   cur,
  input  logic [7:0]         in_byte,
  output mqpf_pkg::state_t   nxt,
  output mqpf_pkg::result_t  res
);

  logic [mqpf_pkg::REM_W-1:0] addend;
  logic [mqpf_pkg::REM_W-1:0] len_sum;
  logic [mqpf_pkg::REM_W-1:0] rem_dec;
  logic [mqpf_pkg::FLD_W-1:0] field_dec;
  logic [2:0]                 cnt_next;
  logic [15:0]                word;
  mqpf_pkg::phase_t           bs_phase;
  logic                       bs_bad;
  mqpf_pkg::phase_t           as_phase;
  logic [2:0]                 as_role;
  logic [2:0]                 cn_role;
  mqpf_pkg::phase_t           np;
  logic                       emit;
  logic [3:0]                 kind;
  logic [mqpf_pkg::REM_W-1:0] value;
  logic [2:0]                 role;

  // length digit placed at its base-128 position
  always_comb begin
    unique case (cur.len_count[1:0])
      2'd0:    addend = {21'b0, in_byte[6:0]};
      2'd1:    addend = {14'b0, in_byte[6:0], 7'b0};
      2'd2:    addend = {7'b0, in_byte[6:0], 14'b0};
      default: addend = {in_byte[6:0], 21'b0};
    endcase
  end

  assign len_sum   = cur.len_count[2] ? cur.remaining : cur.remaining + addend;
  assign cnt_next  = cur.len_count + 3'd1;
  assign rem_dec   = cur.remaining - 28'd1;
  assign field_dec = cur.field_left - 16'd1;
  assign word      = {cur.word_high, in_byte};
  assign cn_role   = mqpf_pkg::connect_next_role(cur.role, cur.cflags);

  // phase at the start of the body
  always_comb begin
    bs_bad = 1'b0;
    unique case (cur.cur_type)
      mqpf_pkg::T_CONNECT:     bs_phase = mqpf_pkg::PH_CSKIP;
      mqpf_pkg::T_PUBLISH:     bs_phase = mqpf_pkg::PH_SLEN_HI;
      mqpf_pkg::T_PUBACK, mqpf_pkg::T_PUBREC, mqpf_pkg::T_PUBREL, mqpf_pkg::T_PUBCOMP,
      mqpf_pkg::T_SUBSCRIBE, mqpf_pkg::T_UNSUBSCRIBE, mqpf_pkg::T_UNSUBACK:
                               bs_phase = mqpf_pkg::PH_PID_HI;
      mqpf_pkg::T_PINGREQ, mqpf_pkg::T_PINGRESP, mqpf_pkg::T_DISCONNECT:
                               bs_phase = mqpf_pkg::PH_SKIP;
      default: begin
        bs_phase = mqpf_pkg::PH_SKIP;
        bs_bad   = 1'b1;
      end
    endcase
  end

  // phase and role after a string ends
  always_comb begin
    as_role = cur.role;
    unique case (cur.cur_type)
      mqpf_pkg::T_CONNECT: begin
        if (cn_role == mqpf_pkg::R_NONE) begin
          as_phase = mqpf_pkg::PH_SKIP;
        end else begin
          as_phase = mqpf_pkg::PH_SLEN_HI;
          as_role  = cn_role;
        end
      end
      mqpf_pkg::T_PUBLISH:
        as_phase = (cur.hdr_flags[2:1] != 2'b00) ? mqpf_pkg::PH_PID_HI : mqpf_pkg::PH_PAYLOAD;
      mqpf_pkg::T_SUBSCRIBE:   as_phase = mqpf_pkg::PH_QOS;
      mqpf_pkg::T_UNSUBSCRIBE: as_phase = mqpf_pkg::PH_SLEN_HI;
      default:                 as_phase = mqpf_pkg::PH_SKIP;
    endcase
  end

  // main parse step
  always_comb begin
    nxt       = cur;
    res.emit  = 1'b0;
    res.kind  = mqpf_pkg::K_HEADER;
    res.value = '0;
    res.role  = mqpf_pkg::R_NONE;
    res.ptype = cur.cur_type;
    res.eop   = 1'b0;
    np        = cur.phase;
    emit      = 1'b1;
    kind      = mqpf_pkg::K_SKIPPED;
    value     = {20'b0, in_byte};
    role      = mqpf_pkg::R_NONE;

    if (cur.phase == mqpf_pkg::PH_HDR) begin
      // fixed header byte
      nxt.cur_type  = in_byte[7:4];
      nxt.hdr_flags = in_byte[3:0];
      nxt.len_count = 3'd0;
      nxt.remaining = '0;
      nxt.role      = mqpf_pkg::R_NONE;
      nxt.cflags    = 8'd0;
      nxt.phase     = mqpf_pkg::PH_LEN;
      res.emit      = 1'b1;
      res.kind      = mqpf_pkg::K_HEADER;
      res.value     = {20'b0, in_byte};
      res.ptype     = in_byte[7:4];
    end else if (cur.phase == mqpf_pkg::PH_LEN) begin
      // remaining length digits
      nxt.remaining = len_sum;
      nxt.len_count = cnt_next;
      if (in_byte[7]) begin
        if (cnt_next >= 3'(mqpf_pkg::MAX_LENGTH_BYTES)) begin
          nxt.phase = mqpf_pkg::PH_HDR;
          res.emit  = 1'b1;
          res.kind  = mqpf_pkg::K_ERROR;
          res.value = mqpf_pkg::E_OVERFLOW;
          res.eop   = 1'b1;
        end
      end else begin
        if (cur.cur_type == mqpf_pkg::T_CONNECT) begin
          nxt.field_left = 16'd7;
        end
        if (cur.cur_type == mqpf_pkg::T_PUBLISH) begin
          nxt.role = mqpf_pkg::R_TOPIC;
        end
        res.emit = 1'b1;
        if (len_sum == '0) begin
          nxt.phase = mqpf_pkg::PH_HDR;
          res.eop   = 1'b1;
          priority if (bs_bad) begin
            res.kind  = mqpf_pkg::K_ERROR;
            res.value = mqpf_pkg::E_UNSUPPORTED;
          end else if (mqpf_pkg::phase_complete(bs_phase, cur.cur_type)) begin
            res.kind  = mqpf_pkg::K_LENGTH;
            res.value = '0;
          end else begin
            res.kind  = mqpf_pkg::K_ERROR;
            res.value = mqpf_pkg::E_UNDERRUN;
          end
        end else begin
          nxt.phase = bs_phase;
          if (bs_bad) begin
            res.kind  = mqpf_pkg::K_ERROR;
            res.value = mqpf_pkg::E_UNSUPPORTED;
          end else begin
            res.kind  = mqpf_pkg::K_LENGTH;
            res.value = len_sum;
          end
        end
      end
    end else begin
      // body bytes
      unique case (cur.phase)
        mqpf_pkg::PH_CSKIP: begin
          nxt.field_left = field_dec;
          if (field_dec == '0) np = mqpf_pkg::PH_CFLAGS;
        end
        mqpf_pkg::PH_CFLAGS: begin
          kind       = mqpf_pkg::K_CFLAGS;
          nxt.cflags = in_byte;
          np         = mqpf_pkg::PH_KA_HI;
        end
        mqpf_pkg::PH_KA_HI: begin
          nxt.word_high = in_byte;
          emit          = 1'b0;
          np            = mqpf_pkg::PH_KA_LO;
        end
        mqpf_pkg::PH_SLEN_HI: begin
          nxt.word_high = in_byte;
          emit          = 1'b0;
          np            = mqpf_pkg::PH_SLEN_LO;
        end
        mqpf_pkg::PH_PID_HI: begin
          nxt.word_high = in_byte;
          emit          = 1'b0;
          np            = mqpf_pkg::PH_PID_LO;
        end
        mqpf_pkg::PH_KA_LO: begin
          kind     = mqpf_pkg::K_KEEPALV;
          value    = {12'b0, word};
          nxt.role = mqpf_pkg::R_CLIENTID;
          np       = mqpf_pkg::PH_SLEN_HI;
        end
        mqpf_pkg::PH_SLEN_LO: begin
          kind  = mqpf_pkg::K_SLEN;
          value = {12'b0, word};
          role  = cur.role;
          if (word == 16'd0) begin
            np       = as_phase;
            nxt.role = as_role;
          end else begin
            nxt.field_left = word;
            np             = mqpf_pkg::PH_SBYTES;
          end
        end
        mqpf_pkg::PH_SBYTES: begin
          kind           = mqpf_pkg::K_SBYTE;
          role           = cur.role;
          nxt.field_left = field_dec;
          if (field_dec == '0) begin
            np       = as_phase;
            nxt.role = as_role;
          end
        end
        mqpf_pkg::PH_PID_LO: begin
          kind  = mqpf_pkg::K_PID;
          value = {12'b0, word};
          priority if (cur.cur_type == mqpf_pkg::T_PUBLISH) begin
            np = mqpf_pkg::PH_PAYLOAD;
          end else if ((cur.cur_type == mqpf_pkg::T_SUBSCRIBE) ||
                       (cur.cur_type == mqpf_pkg::T_UNSUBSCRIBE)) begin
            nxt.role = mqpf_pkg::R_TOPIC;
            np       = mqpf_pkg::PH_SLEN_HI;
          end else begin
            np = mqpf_pkg::PH_SKIP;
          end
        end
        mqpf_pkg::PH_PAYLOAD: begin
          kind = mqpf_pkg::K_PAYLOAD;
        end
        mqpf_pkg::PH_QOS: begin
          kind = mqpf_pkg::K_REQQOS;
          np   = mqpf_pkg::PH_SLEN_HI;
        end
        default: begin
          np = mqpf_pkg::PH_SKIP;
        end
      endcase

      // packet end check
      nxt.remaining = rem_dec;
      if (rem_dec == '0) begin
        nxt.phase = mqpf_pkg::PH_HDR;
        res.emit  = 1'b1;
        res.eop   = 1'b1;
        if (emit && mqpf_pkg::phase_complete(np, cur.cur_type)) begin
          res.kind  = kind;
          res.value = value;
          res.role  = role;
        end else begin
          res.kind  = mqpf_pkg::K_ERROR;
          res.value = mqpf_pkg::E_UNDERRUN;
        end
      end else begin
        nxt.phase = np;
        res.emit  = emit;
        res.kind  = kind;
        res.value = value;
        res.role  = role;
      end
    end
  end

endmodule
